// ===== src/odo_pkg.sv =====
// Shared constants and helpers for the wheel odometry block.
`default_nettype none
package odo_pkg;

  localparam int     FRAC_BITS   = 16;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam int     DIV_W       = 64;
  localparam int     DVS_W       = 32;
  localparam int     HEAD_W      = 19;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:    v = 34'sh03243F6A8;
      5'd1:    v = 34'sh01DAC6705;
      5'd2:    v = 34'sh00FADBAFC;
      5'd3:    v = 34'sh007F56EA6;
      5'd4:    v = 34'sh003FEAB76;
      5'd5:    v = 34'sh001FFD55B;
      5'd6:    v = 34'sh000FFFAAA;
      5'd7:    v = 34'sh0007FFF55;
      5'd8:    v = 34'sh0003FFFEA;
      5'd9:    v = 34'sh0001FFFFD;
      5'd10:   v = 34'sh0000FFFFF;
      5'd11:   v = 34'sh00007FFFF;
      5'd12:   v = 34'sh00003FFFF;
      5'd13:   v = 34'sh00001FFFF;
      5'd14:   v = 34'sh00000FFFF;
      5'd15:   v = 34'sh000007FFF;
      5'd16:   v = 34'sh000003FFF;
      5'd17:   v = 34'sh000001FFF;
      5'd18:   v = 34'sh000000FFF;
      5'd19:   v = 34'sh0000007FF;
      5'd20:   v = 34'sh0000003FF;
      5'd21:   v = 34'sh0000001FF;
      5'd22:   v = 34'sh0000000FF;
      5'd23:   v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/odo_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module odo_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [odo_pkg::DIV_W-1:0]  dividend_i,
  input  wire logic [odo_pkg::DVS_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [odo_pkg::DIV_W-1:0]       quotient_o
);
  import odo_pkg::*;

  logic                busy_q, done_q;
  logic [5:0]          cnt_q;
  logic [DIV_W-1:0]    quo_q;
  logic [DVS_W-1:0]    rem_q, dvs_q;
  logic [DVS_W:0]      trial;
  logic                fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], fits};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

// ===== src/diff_drive_odometry.sv =====
// Differential-drive wheel odometry: pose, speeds and sequence from wheel angles.
// One request at a time: after a request is taken, in_ready_o stays low until the
// result has been loaded into the output register. A zero time step skips the two
// speed divisions, a zero separation register skips the turn division, and a
// stalled output register holds the block until the result is taken. The work is
// done by the shared bit-serial divider, which computes the turn and the two speeds
// in turn, by the CORDIC, one rotation per cycle, and by the heading wrap, a
// reciprocal multiply and one compare and subtract.
`default_nettype none
module diff_drive_odometry #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] left_angle_i,
  input  wire logic signed [31:0] right_angle_i,
  input  wire logic [31:0]        stamp_us_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [odo_pkg::HEAD_W-1:0] heading_o,
  output logic signed [31:0]      speed_linear_o,
  output logic signed [31:0]      speed_angular_o,
  output logic [31:0]             seq_number_o,
  output logic [31:0]             out_stamp_us_o,
  output logic                    turn_is_zero_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import odo_pkg::*;

  localparam longint PiQ    = (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam longint TwoPiQ = (2 * PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam int     QuoSh  = 34 + FRAC_BITS;
  localparam logic signed [33:0] PiQ34   = 34'(PiQ);
  localparam logic [31:0]        PiQ32   = 32'(PiQ);
  localparam logic [31:0]        TwoPiQ32 = 32'(TwoPiQ);
  localparam logic [33:0]        TwoPiQ34 = 34'(TwoPiQ);
  localparam logic signed [33:0] Recip34 = 34'((64'sd1 <<< QuoSh) / TwoPiQ);
  localparam logic signed [33:0] Half34  = 34'(HALF_PI_Q30);
  localparam logic signed [33:0] Pi34    = 34'(PI_Q30);
  localparam logic signed [33:0] Gain34  = 34'(GAIN_Q30);
  localparam logic signed [33:0] Mega34  = 34'sd1000000;
  localparam logic [4:0]         LastIt  = 5'(TRIG_ITERATIONS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MSUM, S_MDIFF, S_DTH, S_DTH_W, S_CINIT, S_CROT, S_MX, S_MY,
    S_ACCY, S_MQ, S_MR, S_MOD, S_MV, S_DV, S_DV_W, S_MW, S_DW, S_DW_W, S_FIN
  } state_e;

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_SEP    = 1'b1
  } reg_e;

  state_e state_q;
  logic [23:0] rad_q, sep_q;
  logic signed [31:0] x_q, y_q, th_q, pl_q, pr_q;
  logic [31:0] pstamp_q, seq_q, stamp_q, dt_q;
  logic signed [33:0] sum_q, diff_q;
  logic signed [31:0] d_q, dth_q, v_q, w_q;
  logic signed [67:0] mul_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [33:0] tabs_q;
  logic [4:0] ci_q;
  logic cneg_q, dneg_q;

  logic out_valid_q;
  logic signed [31:0] o_x_q, o_y_q, o_v_q, o_w_q;
  logic [HEAD_W-1:0] o_h_q;
  logic [31:0] o_seq_q, o_stamp_q;

  logic signed [33:0] mul_a, mul_b;
  logic signed [71:0] mul_ext, prod_sh, xs, ys;
  logic signed [32:0] dl, dr;
  logic signed [33:0] t34, z0, cxs, cys, cc, cs;
  logic signed [63:0] zfull;
  logic [67:0] mag;
  logic signed [64:0] qsig;
  logic div_start, div_done;
  logic [DIV_W-1:0] div_dvd, div_quo;
  logic [DVS_W-1:0] div_dvs;
  logic [33:0] rem0;
  logic [31:0] rem1, mod_m;
  logic cfg_wr, accept;

  odo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign cfg_wr = psel && penable && pwrite;
  assign dl = {left_angle_i[31], left_angle_i} - {pl_q[31], pl_q};
  assign dr = {right_angle_i[31], right_angle_i} - {pr_q[31], pr_q};

  assign mul_ext = {{4{mul_q[67]}}, mul_q};
  assign prod_sh = mul_ext >>> 30;
  assign xs      = {{40{x_q[31]}}, x_q} + prod_sh;
  assign ys      = {{40{y_q[31]}}, y_q} + prod_sh;
  assign mag     = mul_q[67] ? 68'(-mul_q) : 68'(mul_q);
  assign qsig    = dneg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign t34     = {{2{th_q[31]}}, th_q} + {{2{dth_q[31]}}, dth_q} + PiQ34;
  // quotient estimate is exact or one low
  assign rem0    = tabs_q - mul_q[33:0];
  assign rem1    = (rem0 >= TwoPiQ34) ? 32'(rem0 - TwoPiQ34) : rem0[31:0];
  assign mod_m   = (dneg_q && rem1 != '0) ? (TwoPiQ32 - rem1) : rem1;

  assign zfull = 64'(th_q) <<< (30 - FRAC_BITS);
  assign z0    = zfull[33:0];
  assign cxs   = cx_q >>> ci_q;
  assign cys   = cy_q >>> ci_q;
  assign cc    = cneg_q ? -cx_q : cx_q;
  assign cs    = cneg_q ? -cy_q : cy_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MSUM:  begin mul_a = sum_q;  mul_b = {10'd0, rad_q}; end
      S_MDIFF: begin mul_a = diff_q; mul_b = {10'd0, rad_q}; end
      S_MX:    begin mul_a = {{2{d_q[31]}}, d_q}; mul_b = cc; end
      S_MY:    begin mul_a = {{2{d_q[31]}}, d_q}; mul_b = cs; end
      S_MQ:    begin mul_a = tabs_q; mul_b = Recip34; end
      S_MR:    begin mul_a = 34'(mul_q[67:QuoSh]); mul_b = TwoPiQ34; end
      S_MV:    begin mul_a = {{2{d_q[31]}}, d_q}; mul_b = Mega34; end
      S_MW:    begin mul_a = {{2{dth_q[31]}}, dth_q}; mul_b = Mega34; end
      default: ;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = mag[DIV_W-1:0];
    div_dvs   = dt_q;
    case (state_q)
      S_DTH: begin
        div_start = (sep_q != '0);
        div_dvs   = {7'd0, sep_q, 1'b0};
      end
      S_DV, S_DW: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rad_q       <= 24'd1835;
      sep_q       <= 24'd4096;
      x_q         <= '0;
      y_q         <= '0;
      th_q        <= '0;
      pl_q        <= '0;
      pr_q        <= '0;
      pstamp_q    <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mul_q <= mul_a * mul_b;
      if (cfg_wr) begin
        case (reg_e'(paddr[2]))
          REG_RADIUS: rad_q <= pwdata[23:0];
          REG_SEP:    sep_q <= pwdata[23:0];
          default:    ;
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            sum_q    <= {dr[32], dr} + {dl[32], dl};
            diff_q   <= {dr[32], dr} - {dl[32], dl};
            dt_q     <= stamp_us_i - pstamp_q;
            stamp_q  <= stamp_us_i;
            pl_q     <= left_angle_i;
            pr_q     <= right_angle_i;
            pstamp_q <= stamp_us_i;
            state_q  <= S_MSUM;
          end
        end
        S_MSUM:  state_q <= S_MDIFF;
        S_MDIFF: begin
          d_q     <= sat32(mul_ext >>> (FRAC_BITS + 1));
          state_q <= S_DTH;
        end
        S_DTH: begin
          dneg_q <= mul_q[67];
          dth_q  <= '0;
          state_q <= (sep_q != '0) ? S_DTH_W : S_CINIT;
        end
        S_DTH_W: begin
          if (div_done) begin
            dth_q   <= sat32(72'(qsig));
            state_q <= S_CINIT;
          end
        end
        S_CINIT: begin
          cx_q   <= Gain34;
          cy_q   <= '0;
          ci_q   <= '0;
          cneg_q <= 1'b0;
          cz_q   <= z0;
          if (z0 > Half34) begin
            cz_q   <= z0 - Pi34;
            cneg_q <= 1'b1;
          end else if (z0 < -Half34) begin
            cz_q   <= z0 + Pi34;
            cneg_q <= 1'b1;
          end
          state_q <= S_CROT;
        end
        S_CROT: begin
          if (!cz_q[33]) begin
            cx_q <= cx_q - cys;
            cy_q <= cy_q + cxs;
            cz_q <= cz_q - atan_q30(ci_q);
          end else begin
            cx_q <= cx_q + cys;
            cy_q <= cy_q - cxs;
            cz_q <= cz_q + atan_q30(ci_q);
          end
          ci_q <= ci_q + 5'd1;
          if (ci_q == LastIt) state_q <= S_MX;
        end
        S_MX: state_q <= S_MY;
        S_MY: begin
          x_q     <= sat32(xs);
          state_q <= S_ACCY;
        end
        S_ACCY: begin
          y_q     <= sat32(ys);
          dneg_q  <= t34[33];
          tabs_q  <= t34[33] ? 34'(-t34) : 34'(t34);
          state_q <= S_MQ;
        end
        S_MQ: state_q <= S_MR;
        S_MR: state_q <= S_MOD;
        S_MOD: begin
          th_q    <= mod_m - PiQ32;
          v_q     <= '0;
          w_q     <= '0;
          state_q <= (dt_q != '0) ? S_MV : S_FIN;
        end
        S_MV: state_q <= S_DV;
        S_DV: begin
          dneg_q  <= mul_q[67];
          state_q <= S_DV_W;
        end
        S_DV_W: begin
          if (div_done) begin
            v_q     <= sat32(72'(qsig));
            state_q <= S_MW;
          end
        end
        S_MW: state_q <= S_DW;
        S_DW: begin
          dneg_q  <= mul_q[67];
          state_q <= S_DW_W;
        end
        S_DW_W: begin
          if (div_done) begin
            w_q     <= sat32(72'(qsig));
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            o_x_q     <= x_q;
            o_y_q     <= y_q;
            o_h_q     <= th_q[HEAD_W-1:0];
            o_v_q     <= v_q;
            o_w_q     <= w_q;
            o_seq_q   <= seq_q;
            o_stamp_q <= stamp_q;
            seq_q     <= seq_q + 32'd1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = o_x_q;
  assign pos_y_o         = o_y_q;
  assign heading_o       = o_h_q;
  assign speed_linear_o  = o_v_q;
  assign speed_angular_o = o_w_q;
  assign seq_number_o    = o_seq_q;
  assign out_stamp_us_o  = o_stamp_q;
  assign turn_is_zero_o  = (o_w_q == '0);
  assign prdata          = (reg_e'(paddr[2]) == REG_SEP) ? {8'd0, sep_q} : {8'd0, rad_q};
  assign pready          = 1'b1;
endmodule
`default_nettype wire

// ===== src/odo_chk.sv =====
// Port-level checks for the odometry block, bound to its top level.
`default_nettype none
module odo_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] speed_angular_o,
  input wire logic        turn_is_zero_o
);
  // busy right after a request is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after a request");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (turn_is_zero_o == (speed_angular_o == 32'd0)))
    else $error("zero-turn flag disagrees with turn rate");
endmodule

bind diff_drive_odometry odo_chk u_odo_chk (.*);
`default_nettype wire

// ===== dv/diff_drive_odometry_tb.sv =====
// Self-checking testbench for the differential-drive odometry block.
`timescale 1ns / 1ps
module diff_drive_odometry_tb;

  localparam longint PI_Q     = (odo_pkg::PI_Q30 + (64'sd1 << 13)) >>> 14;
  localparam longint TWO_PI_Q = (2 * odo_pkg::PI_Q30 + (64'sd1 << 13)) >>> 14;
  localparam logic [2:0] ADDR_RADIUS = 3'd0;
  localparam logic [2:0] ADDR_SEPARATION = 3'd4;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [odo_pkg::HEAD_W-1:0] heading;
    logic signed [31:0] speed_linear;
    logic signed [31:0] speed_angular;
    logic [31:0] seq_number;
    logic [31:0] stamp;
    logic turn_is_zero;
  } pose_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [31:0] left_angle_i, right_angle_i;
  logic [31:0] stamp_us_i;
  logic signed [31:0] pos_x_o, pos_y_o, speed_linear_o, speed_angular_o;
  logic signed [odo_pkg::HEAD_W-1:0] heading_o;
  logic [31:0] seq_number_o, out_stamp_us_o;
  logic turn_is_zero_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  diff_drive_odometry i_dut (.*);

  // predictor state
  longint radius_q, separation_q;
  longint pose_x, pose_y, pose_th, last_left, last_right;
  logic [31:0] last_stamp, seq_cnt;
  pose_t expected_poses[$];
  longint atan_lut[16] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF};

  int errors = 0;
  idle_mode_e idle_mode = IDLE_NONE;
  int hold_cycles = 0;
  logic signed [31:0] cur_left = 0, cur_right = 0;
  logic [31:0] cur_stamp = 0;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("diff_drive_odometry test failed");
    $finish;
  end

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void heading_trig(longint th, output longint c, output longint s);
    longint z, x, y, nx;
    bit neg;
    z = th * (64'sd1 << 14);
    x = odo_pkg::GAIN_Q30;
    y = 0;
    neg = 0;
    if (z > odo_pkg::HALF_PI_Q30) begin
      z -= odo_pkg::PI_Q30;
      neg = 1;
    end else if (z < -odo_pkg::HALF_PI_Q30) begin
      z += odo_pkg::PI_Q30;
      neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_lut[i];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic pose_t advance_pose(logic signed [31:0] l, logic signed [31:0] r,
                                         logic [31:0] stamp);
    pose_t p;
    logic [31:0] dt;
    longint dl, dr, d, dth, c, s, v, w, m;
    dt = stamp - last_stamp;
    dl = longint'(l) - last_left;
    dr = longint'(r) - last_right;
    d = clamp_word(((dr + dl) * radius_q) >>> 17);
    dth = (separation_q != 0) ? clamp_word(((dr - dl) * radius_q) / (2 * separation_q)) : 0;
    heading_trig(pose_th, c, s);
    pose_x = clamp_word(pose_x + ((d * c) >>> 30));
    pose_y = clamp_word(pose_y + ((d * s) >>> 30));
    m = (pose_th + dth + PI_Q) % TWO_PI_Q;
    if (m < 0) m += TWO_PI_Q;
    pose_th = m - PI_Q;
    v = 0;
    w = 0;
    if (dt != 0) begin
      v = clamp_word((d * 1000000) / longint'(dt));
      w = clamp_word((dth * 1000000) / longint'(dt));
    end
    last_left = l;
    last_right = r;
    last_stamp = stamp;
    p.pos_x = pose_x[31:0];
    p.pos_y = pose_y[31:0];
    p.heading = pose_th[odo_pkg::HEAD_W-1:0];
    p.speed_linear = v[31:0];
    p.speed_angular = w[31:0];
    p.seq_number = seq_cnt;
    p.stamp = stamp;
    p.turn_is_zero = (w == 0);
    seq_cnt++;
    return p;
  endfunction

  // receiver side
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_mode == IDLE_RECEIVER) begin
      out_ready_i <= ($urandom_range(99) >= 56);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ready_i <= ($urandom_range(99) >= 15);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_poses.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got seq %0d", $realtime,
                 seq_number_o);
      end else begin
        e = expected_poses.pop_front();
        check_field("pos_x", e.pos_x, pos_x_o);
        check_field("pos_y", e.pos_y, pos_y_o);
        check_field("heading", e.heading, heading_o);
        check_field("speed_linear", e.speed_linear, speed_linear_o);
        check_field("speed_angular", e.speed_angular, speed_angular_o);
        check_field("seq_number", e.seq_number, seq_number_o);
        check_field("out_stamp_us", e.stamp, out_stamp_us_o);
        check_field("turn_is_zero", e.turn_is_zero, turn_is_zero_o);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(logic signed [31:0] l, logic signed [31:0] r, logic [31:0] s);
    int gap;
    gap = 0;
    if ((idle_mode == IDLE_SENDER && $urandom_range(99) < 56) ||
        (idle_mode == IDLE_BOTH && $urandom_range(99) < 15))
      gap = $urandom_range(1, 40);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    left_angle_i = l;
    right_angle_i = r;
    stamp_us_i = s;
    do @(posedge clk_i); while (!in_ready_o);
    expected_poses.push_back(advance_pose(l, r, s));
    cur_left = l;
    cur_right = r;
    cur_stamp = s;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_poses.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == ADDR_RADIUS) radius_q = data[23:0];
    else separation_q = data[23:0];
  endtask

  task automatic set_geometry(logic [23:0] rad, logic [23:0] sep);
    drain();
    apb_write(ADDR_RADIUS, {8'h00, rad});
    apb_write(ADDR_SEPARATION, {8'h00, sep});
  endtask

  // mostly smooth motion, sometimes a full random jump or a zero time step
  task automatic random_step();
    logic signed [31:0] l, r;
    logic [31:0] s;
    int k;
    k = $urandom_range(99);
    if (k < 12) begin
      l = $urandom;
      r = $urandom;
      s = $urandom;
    end else begin
      l = cur_left + $signed($urandom_range(0, 400000)) - 200000;
      r = cur_right + $signed($urandom_range(0, 400000)) - 200000;
      s = (k < 20) ? cur_stamp : cur_stamp + $urandom_range(1, 50000);
    end
    send_sample(l, r, s);
  endtask

  task automatic test_directed();
    send_sample(0, 0, 0);
    send_sample(32'sd65536, 32'sd65536, 32'd1000);
    send_sample(32'sd65536, 32'sd65536, 32'd1000);
    send_sample(32'sd200000, -32'sd200000, 32'd2000);
    send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'd2001);
    send_sample(32'sh80000000, 32'sh80000000, 32'd2002);
    send_sample(32'sh7FFFFFFF, 32'sh80000000, 32'hFFFFFFFF);
    send_sample(32'sh80000000, 32'sh7FFFFFFF, 32'd5);
    send_sample(-32'sd1, 32'sd1, 32'd5);
    for (int i = 0; i < 6; i++)
      send_sample(cur_left - 32'sd900000, cur_right + 32'sd900000, cur_stamp + 32'd1);
  endtask

  task automatic test_geometry_sweep();
    logic [23:0] rads[5] = '{24'd1, 24'hFFFFFF, 24'd65536, 24'd1835, 24'd300000};
    logic [23:0] seps[5] = '{24'hFFFFFF, 24'd1, 24'd0, 24'd4096, 24'd20000};
    for (int c = 0; c < 5; c++) begin
      set_geometry(rads[c], seps[c]);
      send_sample(32'sh7FFFFFFF, 32'sh80000000, cur_stamp + 32'd1);
      send_sample(32'sh80000000, 32'sh7FFFFFFF, cur_stamp + 32'd1);
      repeat (20) random_step();
    end
  endtask

  task automatic test_random_idling();
    idle_mode_e modes[4] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    for (int p = 0; p < 4; p++) begin
      idle_mode = modes[p];
      set_geometry(24'($urandom_range(1, 200000)), 24'($urandom_range(1, 100000)));
      repeat (150) random_step();
    end
    idle_mode = IDLE_NONE;
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    repeat (6) random_step();
    drain();
    repeat (20) random_step();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    left_angle_i = '0;
    right_angle_i = '0;
    stamp_us_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    radius_q = 1835;
    separation_q = 4096;
    pose_x = 0;
    pose_y = 0;
    pose_th = 0;
    last_left = 0;
    last_right = 0;
    last_stamp = 0;
    seq_cnt = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_geometry_sweep();
    test_random_idling();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("diff_drive_odometry test passed");
    end else begin
      $display("diff_drive_odometry test failed");
    end
    $finish;
  end

endmodule
